/* rtl/md5sh_pkg.sv */
`timescale 1ns / 1ps
// md5sh_pkg: shared types, constants and table functions for the MD5 hasher.
// No dependencies; imported by every module of the block.
package md5sh_pkg;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;
   localparam logic [5:0] LAST_POS = 6'd63;
   localparam logic [5:0] LAST_RND = 6'd63;

   typedef enum logic {
      OP_ABSORB = 1'b0,
      OP_FINISH = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_PREF,
      ST_ROUND,
      ST_FEED,
      ST_OUT
   } state_type;

   // sequencer commands to the round unit
   typedef struct packed {
      logic load;    // copy chaining words into a..d
      logic step;    // one MD5 round
      logic feed;    // add a..d into chaining words
      logic reinit;  // back to initial values
   } rnd_ctrl_type;

   typedef logic [3:0][31:0] word_array_type;

   function automatic logic [31:0] md5_k(input logic [5:0] i);
      logic [31:0] k;
      unique case (i)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   // message word used by round i
   function automatic logic [3:0] md5_g(input logic [5:0] i);
      logic [3:0] lo;
      logic [3:0] g;
      lo = i[3:0];
      unique case (i[5:4])
         2'd0: g = lo;
         2'd1: g = (lo << 2) + lo + 4'd1;
         2'd2: g = (lo << 1) + lo + 4'd5;
         2'd3: g = (lo << 3) - lo;
         default: g = lo;
      endcase
      return g;
   endfunction

   function automatic logic [4:0] md5_rot(input logic [5:0] i);
      logic [4:0] s;
      unique case ({i[5:4], i[1:0]})
         4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
         4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
         default: s = 5'd7;
      endcase
      return s;
   endfunction

endpackage

/* rtl/md5sh_block_buf.sv */
`timescale 1ns / 1ps
// md5sh_block_buf: 64-byte block buffer held as 16 little-endian words.
// Byte-lane writes; registered read returns w[g(i)] + K[i]. Uses md5sh_pkg.
module md5sh_block_buf
   import md5sh_pkg::*;
(
   input  logic        clock,
   input  logic        wr_en,
   input  logic [5:0]  wr_addr,
   input  logic [7:0]  wr_byte,
   input  logic [5:0]  rd_idx,
   output logic [31:0] kw
);

   logic [31:0] mem_ff [16];
   logic [31:0] kw_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr[5:2]][{wr_addr[1:0], 3'b000} +: 8] <= wr_byte;
      end
   end

   // pre-add the round constant so the round path has one add less
   always_ff @(posedge clock) begin
      kw_ff <= mem_ff[md5_g(rd_idx)] + md5_k(rd_idx);
   end

   assign kw = kw_ff;

endmodule

/* rtl/md5sh_round_unit.sv */
`timescale 1ns / 1ps
// md5sh_round_unit: working registers a..d, one MD5 round per step,
// and the four chaining words with feed-forward. Uses md5sh_pkg.
module md5sh_round_unit
   import md5sh_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  rnd_ctrl_type   ctrl,
   input  logic [5:0]     round_idx,
   input  logic [31:0]    kw,
   output word_array_type chain
);

   logic [31:0]    a_ff, b_ff, c_ff, d_ff;
   word_array_type chain_ff;
   logic [31:0]    f;
   logic [31:0]    sum;
   logic [63:0]    rot_wide;
   logic [31:0]    b_new;

   always_comb begin
      unique case (round_idx[5:4])
         2'd0: f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f = (d_ff & b_ff) | (~d_ff & c_ff);
         2'd2: f = b_ff ^ c_ff ^ d_ff;
         2'd3: f = c_ff ^ (b_ff | ~d_ff);
         default: f = b_ff;
      endcase
      sum      = a_ff + f + kw;
      rot_wide = {sum, sum} << md5_rot(round_idx);
      b_new    = b_ff + rot_wide[63:32];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
      end else if (ctrl.step) begin
         a_ff <= d_ff;
         b_ff <= b_new;
         c_ff <= b_ff;
         d_ff <= c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.reinit) begin
         chain_ff <= {IV_D, IV_C, IV_B, IV_A};
      end else if (ctrl.feed) begin
         chain_ff[0] <= chain_ff[0] + a_ff;
         chain_ff[1] <= chain_ff[1] + b_ff;
         chain_ff[2] <= chain_ff[2] + c_ff;
         chain_ff[3] <= chain_ff[3] + d_ff;
      end
   end

   assign chain = chain_ff;

endmodule

/* rtl/md5_stream_hasher_top.sv */
`timescale 1ns / 1ps
// md5_stream_hasher_top: MD5 over a byte stream, sequencer and handshakes.
// Depends on md5sh_pkg, md5sh_block_buf and md5sh_round_unit.
//
// Input channel (req_): one beat per item. Operation absorb adds req_data_byte
// to the message; operation finish pads, compresses and returns the digest.
// Result channel (rsp_): four beats per finish, chaining words A, B, C, D
// (word_index 0..3, last_word on the fourth); read each word's bytes low first.
// Absorb beats are taken back to back while no compression runs. Every 64th
// byte triggers a compression: a prefetch state, 64 rounds on the single shared
// round unit and a feed-forward state. req_ready is low while it runs.
// Finish: the pad bytes are written one per cycle except during the one
// or two compressions, then the digest beats appear, one per cycle that the
// receiver takes them. A stalled receiver simply holds the current beat; no
// new item is taken until the fourth beat is accepted, after which the block
// is back at its initial values for the next message.
// Reset (synchronous, active high) loads the MD5 initial values and clears the
// byte count and bit length; the block is ready in the next cycle.
module md5_stream_hasher_top
   import md5sh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);

   state_type      state_ff, state_in;
   logic [5:0]     fill_ff, fill_in;
   logic [63:0]    bits_ff, bits_in;
   logic [63:0]    snap_ff, snap_in;
   logic           pad_ff, pad_in;
   logic           len_ff, len_in;
   logic [5:0]     round_ff, round_in;
   logic [1:0]     idx_ff, idx_in;

   logic           wr_en;
   logic [7:0]     wr_byte;
   logic [5:0]     rd_idx;
   logic [31:0]    kw;
   rnd_ctrl_type   rctrl;
   word_array_type chain;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         bits_ff  <= '0;
         pad_ff   <= 1'b0;
         len_ff   <= 1'b0;
         round_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
         pad_ff   <= pad_in;
         len_ff   <= len_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      bits_in   = bits_ff;
      snap_in   = snap_ff;
      pad_in    = pad_ff;
      len_in    = len_ff;
      round_in  = round_ff;
      idx_in    = idx_ff;
      wr_en     = 1'b0;
      wr_byte   = req_data_byte;
      rd_idx    = round_ff;
      rctrl     = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               wr_en   = 1'b1;
               fill_in = fill_ff + 6'd1;
               if (req_operation == OP_FINISH) begin
                  wr_byte = PAD_MARK;
                  snap_in = bits_ff;
                  pad_in  = 1'b1;
               end else begin
                  bits_in = bits_ff + 64'd8;
               end
               state_in = (fill_ff == LAST_POS) ? ST_PREF :
                          (req_operation == OP_FINISH) ? ST_PAD : ST_IDLE;
            end
         end
         ST_PAD: begin
            wr_en   = 1'b1;
            fill_in = fill_ff + 6'd1;
            // length bytes fill the last eight slots of the final block
            if (len_ff || fill_ff == LEN_POS) begin
               len_in  = 1'b1;
               wr_byte = snap_ff[{fill_ff[2:0], 3'b000} +: 8];
            end else begin
               wr_byte = '0;
            end
            if (fill_ff == LAST_POS) begin
               state_in = ST_PREF;
            end
         end
         ST_PREF: begin
            rctrl.load = 1'b1;
            state_in   = ST_ROUND;
         end
         ST_ROUND: begin
            rctrl.step = 1'b1;
            rd_idx     = round_ff + 6'd1;
            round_in   = round_ff + 6'd1;
            if (round_ff == LAST_RND) begin
               state_in = ST_FEED;
            end
         end
         ST_FEED: begin
            rctrl.feed = 1'b1;
            priority if (len_ff) begin
               state_in = ST_OUT;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  rctrl.reinit = 1'b1;
                  bits_in      = '0;
                  pad_in       = 1'b0;
                  len_in       = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   md5sh_block_buf u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff),
      .wr_byte (wr_byte),
      .rd_idx  (rd_idx),
      .kw      (kw)
   );

   md5sh_round_unit u_round (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (rctrl),
      .round_idx (round_ff),
      .kw        (kw),
      .chain     (chain)
   );

   assign rsp_digest_word = chain[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 2'd3);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input and result channels active together");

   a_full_block_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && fill_ff == LAST_POS) |=> !req_ready)
      else $error("full block did not start a compression");

   a_round_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ROUND) |-> (round_ff == 6'd0))
      else $error("round counter left nonzero outside rounds");

   a_digest_after_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (len_ff && fill_ff == 6'd0))
      else $error("digest shown before length block was compressed");

endmodule
